// ===== hdl/assert_macros.svh =====
// Assertion helpers shared by the RTL. Define ASSERT_OFF to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rstn, prop, msg)
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg)
`endif

`endif

// ===== hdl/bpc_pkg.sv =====
`default_nettype none
package bpc_pkg;

  localparam int HOLD_COUNT_BITS_DEF = 16;
  localparam int CHECK_W             = 8;
  localparam int THR_W               = 16;
  localparam int CFG_IDX_W           = 3;
  localparam int CFG_DATA_W          = 16;

  localparam logic [CHECK_W-1:0] ENTRY_CHECKS_RST = 8'd10;
  localparam logic [CHECK_W-1:0] EXIT_CHECKS_RST  = 8'd10;
  localparam logic [THR_W-1:0]   SHORT_THR_RST    = 16'd5;
  localparam logic [THR_W-1:0]   LONG_THR_RST     = 16'd100;
  localparam logic [THR_W-1:0]   HOLD_THR_RST     = 16'd300;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ENTRY_CHECKS = 3'd0,
    CFG_EXIT_CHECKS  = 3'd1,
    CFG_SHORT_THR    = 3'd2,
    CFG_LONG_THR     = 3'd3,
    CFG_HOLD_THR     = 3'd4
  } cfg_index_t;

  typedef struct packed {
    logic [CHECK_W-1:0] entry_checks;
    logic [CHECK_W-1:0] exit_checks;
    logic [THR_W-1:0]   short_threshold;
    logic [THR_W-1:0]   long_threshold;
    logic [THR_W-1:0]   hold_threshold;
  } cfg_regs_t;

  typedef struct packed {
    logic hold_active;
    logic hold_release;
    logic long_press;
    logic short_press;
    logic fast_press;
  } result_t;

endpackage
`default_nettype wire

// ===== hdl/bpc_cfg_regs.sv =====
`default_nettype none
module bpc_cfg_regs (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             wr_en,
  input  wire logic [bpc_pkg::CFG_IDX_W-1:0]    wr_index,
  input  wire logic [bpc_pkg::CFG_DATA_W-1:0]   wr_data,
  output bpc_pkg::cfg_regs_t                    cfg
);

  bpc_pkg::cfg_regs_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.entry_checks    <= bpc_pkg::ENTRY_CHECKS_RST;
      cfg_r.exit_checks     <= bpc_pkg::EXIT_CHECKS_RST;
      cfg_r.short_threshold <= bpc_pkg::SHORT_THR_RST;
      cfg_r.long_threshold  <= bpc_pkg::LONG_THR_RST;
      cfg_r.hold_threshold  <= bpc_pkg::HOLD_THR_RST;
    end else if (wr_en) begin
      unique case (bpc_pkg::cfg_index_t'(wr_index))
        bpc_pkg::CFG_ENTRY_CHECKS: cfg_r.entry_checks <= wr_data[bpc_pkg::CHECK_W-1:0];
        bpc_pkg::CFG_EXIT_CHECKS:  cfg_r.exit_checks  <= wr_data[bpc_pkg::CHECK_W-1:0];
        bpc_pkg::CFG_SHORT_THR:    cfg_r.short_threshold <= wr_data[bpc_pkg::THR_W-1:0];
        bpc_pkg::CFG_LONG_THR:     cfg_r.long_threshold  <= wr_data[bpc_pkg::THR_W-1:0];
        bpc_pkg::CFG_HOLD_THR:     cfg_r.hold_threshold  <= wr_data[bpc_pkg::THR_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule
`default_nettype wire

// ===== hdl/bpc_classify.sv =====
`default_nettype none
`include "assert_macros.svh"
module bpc_classify #(
  parameter int HOLD_COUNT_BITS = bpc_pkg::HOLD_COUNT_BITS_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           step_en,
  input  wire logic           level,
  input  wire bpc_pkg::cfg_regs_t cfg,
  output bpc_pkg::result_t    res
);

  localparam int CMP_W = (HOLD_COUNT_BITS > bpc_pkg::THR_W) ? HOLD_COUNT_BITS
                                                            : bpc_pkg::THR_W;
  localparam logic [HOLD_COUNT_BITS-1:0] HOLD_MAX = {HOLD_COUNT_BITS{1'b1}};

  logic                            pressed_r, pressed_nxt;
  logic [bpc_pkg::CHECK_W-1:0]     deb_cnt_r, deb_cnt_nxt;
  logic [HOLD_COUNT_BITS-1:0]      hold_ticks_r, hold_ticks_nxt;
  logic                            short_r, short_nxt;
  logic                            long_r, long_nxt;
  logic                            hold_r, hold_nxt;
  logic [bpc_pkg::CHECK_W-1:0]     deb_inc;
  logic [HOLD_COUNT_BITS-1:0]      ticks_inc;
  logic [CMP_W-1:0]                ticks_ext;

  assign deb_inc   = deb_cnt_r + 1'b1;
  assign ticks_inc = (hold_ticks_r != HOLD_MAX) ? hold_ticks_r + 1'b1 : hold_ticks_r;
  assign ticks_ext = CMP_W'(ticks_inc);

  always_comb begin
    pressed_nxt    = pressed_r;
    deb_cnt_nxt    = deb_cnt_r;
    hold_ticks_nxt = hold_ticks_r;
    short_nxt      = short_r;
    long_nxt       = long_r;
    hold_nxt       = hold_r;
    res            = '0;
    if (!pressed_r) begin
      if (level) begin
        deb_cnt_nxt = '0;
      end else if (deb_inc >= cfg.entry_checks) begin
        res.fast_press = 1'b1;
        deb_cnt_nxt    = '0;
        hold_ticks_nxt = '0;
        pressed_nxt    = 1'b1;
      end else begin
        deb_cnt_nxt = deb_inc;
      end
    end else if (!level) begin
      deb_cnt_nxt    = '0;
      hold_ticks_nxt = ticks_inc;
      if (ticks_ext > CMP_W'(cfg.short_threshold)) begin
        short_nxt = 1'b1;
      end
      if (ticks_ext > CMP_W'(cfg.long_threshold)) begin
        short_nxt = 1'b0;
        long_nxt  = 1'b1;
      end
      if (ticks_ext > CMP_W'(cfg.hold_threshold)) begin
        long_nxt = 1'b0;
        hold_nxt = 1'b1;
      end
    end else if (deb_inc >= cfg.exit_checks) begin
      res.short_press  = short_r;
      res.long_press   = long_r;
      res.hold_release = hold_r;
      short_nxt        = 1'b0;
      long_nxt         = 1'b0;
      hold_nxt         = 1'b0;
      hold_ticks_nxt   = '0;
      deb_cnt_nxt      = '0;
      pressed_nxt      = 1'b0;
    end else begin
      deb_cnt_nxt = deb_inc;
    end
    res.hold_active = hold_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pressed_r    <= 1'b0;
      deb_cnt_r    <= '0;
      hold_ticks_r <= '0;
      short_r      <= 1'b0;
      long_r       <= 1'b0;
      hold_r       <= 1'b0;
    end else if (step_en) begin
      pressed_r    <= pressed_nxt;
      deb_cnt_r    <= deb_cnt_nxt;
      hold_ticks_r <= hold_ticks_nxt;
      short_r      <= short_nxt;
      long_r       <= long_nxt;
      hold_r       <= hold_nxt;
    end
  end

  `ASSERT_NEVER(a_flags_idle, clk, rst_n, !pressed_r && (short_r || long_r || hold_r), "classification set while released")
  `ASSERT_NEVER(a_ticks_idle, clk, rst_n, !pressed_r && (hold_ticks_r != '0), "hold counter nonzero while released")
  `ASSERT_CLK(a_ticks_step, clk, rst_n, step_en && pressed_r && !level && (hold_ticks_r != HOLD_MAX) |=> hold_ticks_r == HOLD_COUNT_BITS'($past(hold_ticks_r) + 1'b1), "hold counter did not advance")

endmodule
`default_nettype wire

// ===== hdl/button_press_classifier.sv =====
// Pipeline: an accepted sample is held in the input register (s1), and its result moves
// into the output result register when s1 fires; a stall on out_tready holds it in s1.
// Throughput: one sample per cycle while out_tready keeps up; while a result waits on
// out_tready, the input register takes at most one more sample and in_tready then drops.
// Reset: synchronous, active low; clears the classifier state, the pipeline valids
// and restores the default limits and thresholds. No clearing pass is needed.
`default_nettype none
`include "assert_macros.svh"
module button_press_classifier #(
  parameter int HOLD_COUNT_BITS = bpc_pkg::HOLD_COUNT_BITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_tvalid,
  output      logic                           in_tready,
  input  wire logic [7:0]                     in_tdata,  // [0] button_level
  output      logic                           out_tvalid,
  input  wire logic                           out_tready,
  // [0] fast_press, [1] short_press, [2] long_press, [3] hold_release, [4] hold_active
  output      logic [7:0]                     out_tdata,
  input  wire logic                           cfg_valid,
  output      logic                           cfg_ready,
  input  wire logic [bpc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [bpc_pkg::CFG_DATA_W-1:0] cfg_data
);

  bpc_pkg::cfg_regs_t cfg;
  bpc_pkg::result_t   res;
  bpc_pkg::result_t   out_res_r;
  logic               s1_valid_r;
  logic               s1_level_r;
  logic               out_valid_r;
  logic               s1_fire;

  assign cfg_ready = 1'b1;
  assign s1_fire   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_fire;

  bpc_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  bpc_classify #(
    .HOLD_COUNT_BITS (HOLD_COUNT_BITS)
  ) u_classify (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (s1_fire),
    .level   (s1_level_r),
    .cfg     (cfg),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_level_r <= in_tdata[0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_res_r};

  `ASSERT_CLK(a_fast_no_hold, clk, rst_n, out_valid_r && out_res_r.fast_press |-> !out_res_r.hold_active && !out_res_r.short_press && !out_res_r.long_press && !out_res_r.hold_release, "press accepted together with release or hold")
  `ASSERT_CLK(a_release_clears, clk, rst_n, out_valid_r && (out_res_r.short_press || out_res_r.long_press || out_res_r.hold_release) |-> !out_res_r.hold_active, "hold still active after release")

endmodule
`default_nettype wire

// ===== bench/button_press_classifier_checker.sv =====
`timescale 1ns / 1ps
module button_press_classifier_checker #(
  parameter int HOLD_BITS = bpc_pkg::HOLD_COUNT_BITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_tvalid,
  input  wire logic                           in_tready,
  input  wire logic [7:0]                     in_tdata,  // [0] button_level
  input  wire logic                           out_tvalid,
  input  wire logic                           out_tready,
  // [0] fast_press, [1] short_press, [2] long_press, [3] hold_release, [4] hold_active
  input  wire logic [7:0]                     out_tdata,
  input  wire logic                           cfg_valid,
  input  wire logic                           cfg_ready,
  input  wire logic [bpc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [bpc_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                                  mismatches,
  output int                                  outstanding,
  output int                                  results_checked
);
  import bpc_pkg::*;

  logic [CHECK_W-1:0]   entry_limit;
  logic [CHECK_W-1:0]   exit_limit;
  logic [THR_W-1:0]     short_thr;
  logic [THR_W-1:0]     long_thr;
  logic [THR_W-1:0]     hold_thr;

  logic                 pressed;
  logic [CHECK_W-1:0]   stable_count;
  logic [HOLD_BITS-1:0] hold_ticks;
  logic                 short_flag;
  logic                 long_flag;
  logic                 hold_flag;

  result_t              expected_results[$];
  int                   error_total;
  int                   checked_total;

  function automatic result_t classify_sample(input logic released);
    result_t r;
    r = '0;
    if (!pressed) begin
      if (released) begin
        stable_count = '0;
      end else begin
        stable_count = stable_count + 1'b1;
        if (stable_count >= entry_limit) begin
          r.fast_press = 1'b1;
          stable_count = '0;
          hold_ticks   = '0;
          pressed      = 1'b1;
        end
      end
    end else if (!released) begin
      stable_count = '0;
      if (hold_ticks != '1) hold_ticks = hold_ticks + 1'b1;
      if (hold_ticks > short_thr) short_flag = 1'b1;
      if (hold_ticks > long_thr) begin
        short_flag = 1'b0;
        long_flag  = 1'b1;
      end
      if (hold_ticks > hold_thr) begin
        long_flag = 1'b0;
        hold_flag = 1'b1;
      end
    end else begin
      stable_count = stable_count + 1'b1;
      if (stable_count >= exit_limit) begin
        r.short_press  = short_flag;
        r.long_press   = long_flag;
        r.hold_release = hold_flag;
        short_flag   = 1'b0;
        long_flag    = 1'b0;
        hold_flag    = 1'b0;
        hold_ticks   = '0;
        stable_count = '0;
        pressed      = 1'b0;
      end
    end
    r.hold_active = hold_flag;
    return r;
  endfunction

  initial begin
    error_total   = 0;
    checked_total = 0;
  end

  always @(posedge clk) begin
    result_t want;
    if (!rst_n) begin
      entry_limit  = ENTRY_CHECKS_RST;
      exit_limit   = EXIT_CHECKS_RST;
      short_thr    = SHORT_THR_RST;
      long_thr     = LONG_THR_RST;
      hold_thr     = HOLD_THR_RST;
      pressed      = 1'b0;
      stable_count = '0;
      hold_ticks   = '0;
      short_flag   = 1'b0;
      long_flag    = 1'b0;
      hold_flag    = 1'b0;
      expected_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_ENTRY_CHECKS: entry_limit = cfg_data[CHECK_W-1:0];
          CFG_EXIT_CHECKS:  exit_limit  = cfg_data[CHECK_W-1:0];
          CFG_SHORT_THR:    short_thr   = cfg_data[THR_W-1:0];
          CFG_LONG_THR:     long_thr    = cfg_data[THR_W-1:0];
          CFG_HOLD_THR:     hold_thr    = cfg_data[THR_W-1:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) expected_results.push_back(classify_sample(in_tdata[0]));
      if (out_tvalid && out_tready) begin
        if (expected_results.size() == 0) begin
          error_total++;
          $display("%0t: unexpected result transaction, expected none, actual tdata %b",
                   $time, out_tdata);
        end else begin
          want = expected_results.pop_front();
          checked_total++;
          if (out_tdata !== 8'(want)) begin
            error_total++;
            $display("%0t: result %0d mismatch, expected fast=%b short=%b long=%b rel=%b held=%b",
                     $time, checked_total, want.fast_press, want.short_press, want.long_press,
                     want.hold_release, want.hold_active);
            $display("%0t: result %0d mismatch, actual   fast=%b short=%b long=%b rel=%b held=%b pad=%b",
                     $time, checked_total, out_tdata[0], out_tdata[1], out_tdata[2],
                     out_tdata[3], out_tdata[4], out_tdata[7:5]);
          end
        end
      end
    end
    mismatches      <= error_total;
    outstanding     <= expected_results.size();
    results_checked <= checked_total;
  end

endmodule

// ===== bench/button_press_classifier_test.sv =====
`timescale 1ns / 1ps
module button_press_classifier_test;
  import bpc_pkg::*;

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int DRAIN_CYCLES = 8;
  localparam int IDLE_PERCENT = 21;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_FIRST = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_LAST  = 3'd7;
  localparam logic RELEASED = 1'b1;
  localparam logic PRESSED  = 1'b0;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [7:0]            in_tdata;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [7:0]            out_tdata;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int mismatches;
  int outstanding;
  int results_checked;
  int samples_sent;
  int settings_used;
  int cycles;
  logic quiet;
  logic [CHECK_W-1:0] entry_now;
  logic [CHECK_W-1:0] exit_now;

  button_press_classifier DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  button_press_classifier_checker classifier_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .mismatches      (mismatches),
    .outstanding     (outstanding),
    .results_checked (results_checked)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    out_tready <= quiet || ($urandom_range(99) >= IDLE_PERCENT);
  end

  task automatic send_sample(input logic level);
    if (!quiet) begin
      while ($urandom_range(99) < IDLE_PERCENT) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    in_tvalid <= 1'b1;
    in_tdata  <= 8'(level);
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    samples_sent++;
  endtask

  task automatic send_run(input logic level, input int count);
    repeat (count) send_sample(level);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // The block is brought to rest first; the classifier state itself carries over.
  task automatic configure(input logic [CHECK_W-1:0] entry, input logic [CHECK_W-1:0] leave,
                           input logic [THR_W-1:0] short_t, input logic [THR_W-1:0] long_t,
                           input logic [THR_W-1:0] hold_t);
    logic [CFG_IDX_W-1:0] spare_index;
    spare_index = CFG_IDX_W'(CFG_UNUSED_FIRST
                  + $urandom_range(CFG_UNUSED_LAST - CFG_UNUSED_FIRST));
    drain();
    write_reg(CFG_ENTRY_CHECKS, {(CFG_DATA_W-CHECK_W)'($urandom), entry});
    write_reg(CFG_EXIT_CHECKS, {(CFG_DATA_W-CHECK_W)'($urandom), leave});
    write_reg(CFG_SHORT_THR, short_t);
    write_reg(CFG_LONG_THR, long_t);
    write_reg(CFG_HOLD_THR, hold_t);
    write_reg(spare_index, CFG_DATA_W'($urandom));
    cfg_valid <= 1'b0;
    entry_now = entry;
    exit_now  = leave;
    settings_used++;
  endtask

  task automatic bounce(input logic level, input int limit);
    repeat ($urandom_range(3)) begin
      send_run(level, $urandom_range(1, (limit > 1) ? limit - 1 : 1));
      send_run(!level, $urandom_range(1, 3));
    end
  endtask

  task automatic press_sequence(input int cap);
    int hold_len;
    hold_len = $urandom_range(cap);
    bounce(PRESSED, entry_now);
    send_run(PRESSED, entry_now + hold_len);
    bounce(RELEASED, exit_now);
    send_run(RELEASED, exit_now + $urandom_range(4));
  endtask

  task automatic random_phase(input int count, input int cap);
    int target;
    target = samples_sent + count;
    while (samples_sent < target) begin
      if ($urandom_range(99) < 80) begin
        press_sequence(cap);
      end else begin
        repeat ($urandom_range(1, 12)) send_sample(1'($urandom_range(1)));
      end
    end
  endtask

  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Run stopped at the cycle limit with %0d results outstanding.", outstanding);
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    samples_sent  = 0;
    settings_used = 0;
    quiet         = 1'b0;
    rst_n         = 1'b0;
    in_tvalid     = 1'b0;
    in_tdata      = '0;
    cfg_valid     = 1'b0;
    cfg_index     = CFG_ENTRY_CHECKS;
    cfg_data      = '0;
    entry_now     = ENTRY_CHECKS_RST;
    exit_now      = EXIT_CHECKS_RST;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Zero entry limit, then a press that climbs through all three classes.
    configure(8'd0, 8'd1, 16'd0, 16'd2, 16'd4);
    send_sample(RELEASED);
    send_run(PRESSED, 7);
    send_sample(RELEASED);

    // Short press with an interrupted release, then a release before any class.
    configure(8'd1, 8'd2, 16'd2, 16'hFFFF, 16'hFFFF);
    send_run(PRESSED, 4);
    send_sample(RELEASED);
    send_sample(PRESSED);
    send_run(RELEASED, 2);
    send_sample(PRESSED);
    send_run(RELEASED, 2);

    // Thresholds out of order, so that short and hold are reported together.
    configure(8'd1, 8'd1, 16'd1, 16'd3, 16'd2);
    send_run(PRESSED, 4);
    send_sample(RELEASED);

    // Limits lowered while a count is in progress.
    configure(8'd8, 8'd8, SHORT_THR_RST, LONG_THR_RST, HOLD_THR_RST);
    send_run(PRESSED, 5);
    configure(8'd2, 8'd8, SHORT_THR_RST, LONG_THR_RST, HOLD_THR_RST);
    send_sample(PRESSED);
    send_run(RELEASED, 5);
    configure(8'd2, 8'd3, SHORT_THR_RST, LONG_THR_RST, HOLD_THR_RST);
    send_sample(RELEASED);

    // Largest limits and thresholds.
    configure(8'd255, 8'd255, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_run(PRESSED, 254);
    send_sample(RELEASED);
    send_run(PRESSED, 256);
    send_run(RELEASED, 255);

    configure(ENTRY_CHECKS_RST, EXIT_CHECKS_RST, SHORT_THR_RST, LONG_THR_RST, HOLD_THR_RST);
    random_phase(60, 120);

    quiet = 1'b1;
    configure(8'd1, 8'd1, 16'd3, 16'd8, 16'd15);
    random_phase(130, 20);
    quiet = 1'b0;

    configure(8'd4, 8'd3, 16'd0, 16'd0, 16'd0);
    random_phase(80, 6);

    configure(8'd2, 8'd5, 16'd20, 16'd10, 16'd5);
    random_phase(100, 25);

    repeat (3) begin
      configure(CHECK_W'($urandom_range(1, 8)), CHECK_W'($urandom_range(1, 8)),
                THR_W'($urandom_range(40)), THR_W'($urandom_range(40)),
                THR_W'($urandom_range(40)));
      random_phase(50, 45);
    end

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d button samples under %0d register settings, limits at both ends.",
             samples_sent, settings_used);
    $display("Compared %0d results; %0d mismatches, %0d left unmatched.",
             results_checked, mismatches, outstanding);
    if (mismatches == 0 && outstanding == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
